FILE: hw/rtl/cube_face_grid_to_sphere_top_defines.svh
// ----------------------------------------------------------------------------
// cube_face_grid_to_sphere_top_defines
// assertion macros used by the top rtl file of the sphere vertex block
// ----------------------------------------------------------------------------
`ifndef CUBE_FACE_GRID_TO_SPHERE_TOP_DEFINES_SVH
`define CUBE_FACE_GRID_TO_SPHERE_TOP_DEFINES_SVH

// condition that holds at every edge out of reset
`define CFS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent, delayed by the dly argument
`define CFS_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##dly (cons)) else $error(msg);

`endif

FILE: hw/rtl/cfsph_pkg.sv
// ----------------------------------------------------------------------------
// cfsph_pkg
// constants, types and the face axis table of the sphere vertex block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfsph_pkg;

  localparam int unsigned GridMax   = 256;
  localparam int unsigned SpanW     = $clog2(GridMax);
  localparam int unsigned RadiusW   = 15;
  localparam int unsigned GridW     = 9;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned FaceW     = 3;
  localparam int unsigned PosW      = 24;
  localparam int unsigned CfgW      = 15;
  localparam int unsigned FaceCount = 6;

  localparam logic [RadiusW-1:0] RadiusReset = 15'd6300;
  localparam logic [GridW-1:0]   GridReset   = GridW'(GridMax);

  localparam int unsigned DivSteps  = 17;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned OutSteps  = 24;
  localparam int unsigned Latency   = 1 + DivSteps + 3 + SqrtSteps + 2 + OutSteps + 1;

  typedef enum logic {
    CfgRadius = 1'b0,
    CfgGrid   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SrcS    = 2'd0,
    SrcT    = 2'd1,
    SrcHalf = 2'd2
  } axis_src_e;

  typedef struct packed {
    axis_src_e src;
    logic      neg;
  } axis_map_t;

  typedef axis_map_t [2:0] face_map_t;

  typedef struct packed {
    logic [SpanW-1:0]    rem;
    logic [DivSteps-1:0] lo;
    logic [DivSteps-1:0] quo;
  } tdiv_t;

  typedef struct packed {
    logic [FaceW-1:0] face;
    tdiv_t            s;
    tdiv_t            t;
  } div_stage_t;

  typedef struct packed {
    logic [FaceW-1:0] face;
    logic             ns;
    logic             nt;
    logic [15:0]      ms;
    logic [15:0]      mt;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [31:0]      v;
  } sqrt_stage_t;

  typedef struct packed {
    logic [31:0]         rem;
    logic [OutSteps-1:0] lo;
    logic [OutSteps-1:0] quo;
  } odiv_t;

  typedef struct packed {
    logic            ok;
    logic [2:0]      neg;
    logic [31:0]     len;
    odiv_t [2:0]     ax;
  } out_stage_t;

  localparam axis_map_t PS = '{src: SrcS,    neg: 1'b0};
  localparam axis_map_t NS = '{src: SrcS,    neg: 1'b1};
  localparam axis_map_t PT = '{src: SrcT,    neg: 1'b0};
  localparam axis_map_t NT = '{src: SrcT,    neg: 1'b1};
  localparam axis_map_t PH = '{src: SrcHalf, neg: 1'b0};
  localparam axis_map_t NH = '{src: SrcHalf, neg: 1'b1};

  // entry 0 is x, 1 is y, 2 is z
  function automatic face_map_t face_map(logic [FaceW-1:0] face);
    face_map_t m;
    case (face)
      3'd0:    m = {PH, PT, PS};
      3'd1:    m = {NS, PT, PH};
      3'd2:    m = {NH, PT, NS};
      3'd3:    m = {PS, PT, NH};
      3'd4:    m = {NT, PH, PS};
      3'd5:    m = {PT, NH, PS};
      default: m = {PH, PH, PH};
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/cube_face_grid_to_sphere_top.sv
// ----------------------------------------------------------------------------
// cube_face_grid_to_sphere_top
// maps a cube face grid point to its vertex on a sphere of given radius
// ----------------------------------------------------------------------------
// One grid point is taken in every clock cycle (busy_o stays low) and its
// vertex appears on pos_*_o with valid_o once it has passed the bit-serial
// pipeline: 17 stages of tangent division, 32 stages of square root and 24
// stages of the final scaling division, one result bit per stage. Results
// cannot be held off; each beat stands on the outputs for one cycle. The user
// must write configuration only while no point is in flight; the block
// itself does not enforce this.
`timescale 1ns / 1ps

module cube_face_grid_to_sphere_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [cfsph_pkg::FaceW-1:0]   face_i,
  input  logic [cfsph_pkg::CoordW-1:0]  column_i,
  input  logic [cfsph_pkg::CoordW-1:0]  row_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [cfsph_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                          valid_o,
  output logic [cfsph_pkg::PosW-1:0]    pos_x_o,
  output logic [cfsph_pkg::PosW-1:0]    pos_y_o,
  output logic [cfsph_pkg::PosW-1:0]    pos_z_o
);
  import cfsph_pkg::*;

  `include "cube_face_grid_to_sphere_top_defines.svh"

  // config registers
  logic [RadiusW-1:0] radius_q;
  logic [GridW-1:0]   grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      grid_q   <= GridReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgRadius: radius_q <= cfg_wdata_i[RadiusW-1:0];
        CfgGrid:   grid_q   <= cfg_wdata_i[GridW-1:0];
        default:   ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // grid span n-1
  logic [GridW-1:0] grid_c;
  logic [SpanW-1:0] span;

  always_comb begin
    if (grid_q < GridW'(2)) begin
      grid_c = GridW'(2);
    end else if (grid_q > GridW'(GridMax)) begin
      grid_c = GridW'(GridMax);
    end else begin
      grid_c = grid_q;
    end
    span = SpanW'(grid_c - GridW'(1));
  end

  function automatic tdiv_t tdiv_step(tdiv_t a, logic [SpanW-1:0] d);
    tdiv_t        r;
    logic [SpanW:0] t;
    t    = {a.rem, a.lo[DivSteps-1]};
    r.lo = {a.lo[DivSteps-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = SpanW'(t - {1'b0, d});
      r.quo = {a.quo[DivSteps-2:0], 1'b1};
    end else begin
      r.rem = t[SpanW-1:0];
      r.quo = {a.quo[DivSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic tdiv_t tdiv_init(logic [CoordW-1:0] idx, logic [SpanW-1:0] d);
    tdiv_t               r;
    logic [SpanW-1:0]    ic;
    logic [SpanW+15:0]   num;
    ic    = (SpanW'(idx) > d) ? d : SpanW'(idx);
    num   = {ic, 16'd0} + (SpanW+16)'(d >> 1);
    r.rem = SpanW'(num >> DivSteps);
    r.lo  = num[DivSteps-1:0];
    r.quo = '0;
    return r;
  endfunction

  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t a);
    sqrt_stage_t r;
    logic [35:0] t;
    logic [35:0] trial;
    r     = a;
    t     = {a.rem, a.v[31:30]};
    trial = {2'b00, a.root, 2'b01};
    r.v   = {a.v[29:0], 2'b00};
    if (t >= trial) begin
      r.rem  = 34'(t - trial);
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = t[33:0];
      r.root = {a.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic odiv_t odiv_step(odiv_t a, logic [31:0] d);
    odiv_t       r;
    logic [32:0] t;
    t    = {a.rem, a.lo[OutSteps-1]};
    r.lo = {a.lo[OutSteps-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = 32'(t - {1'b0, d});
      r.quo = {a.quo[OutSteps-2:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.quo = {a.quo[OutSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  // tangent division pipe
  logic [DivSteps:0] dv_q;
  div_stage_t        div_q [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0].face <= face_i;
    div_q[0].s    <= tdiv_init(column_i, span);
    div_q[0].t    <= tdiv_init(row_i, span);
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      div_q[k+1].face <= div_q[k].face;
      div_q[k+1].s    <= tdiv_step(div_q[k].s, span);
      div_q[k+1].t    <= tdiv_step(div_q[k].t, span);
    end
  end

  // offset magnitudes, then squares
  logic               av_q, bv_q;
  logic [FaceW-1:0]   a_face_q, b_face_q;
  logic               a_ns_q, a_nt_q, b_ns_q, b_nt_q;
  logic [15:0]        a_ms_q, a_mt_q, b_ms_q, b_mt_q;
  logic [30:0]        b_ss_q, b_tt_q;
  logic [DivSteps-1:0] us, ut;

  assign us = div_q[DivSteps].s.quo;
  assign ut = div_q[DivSteps].t.quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
      bv_q <= 1'b0;
    end else begin
      av_q <= dv_q[DivSteps];
      bv_q <= av_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_face_q <= div_q[DivSteps].face;
    a_ns_q   <= (us < 17'd32768);
    a_nt_q   <= (ut < 17'd32768);
    a_ms_q   <= (us < 17'd32768) ? 16'(17'd32768 - us) : 16'(us - 17'd32768);
    a_mt_q   <= (ut < 17'd32768) ? 16'(17'd32768 - ut) : 16'(ut - 17'd32768);
    b_face_q <= a_face_q;
    b_ns_q   <= a_ns_q;
    b_nt_q   <= a_nt_q;
    b_ms_q   <= a_ms_q;
    b_mt_q   <= a_mt_q;
    b_ss_q   <= 31'(a_ms_q * a_ms_q);
    b_tt_q   <= 31'(a_mt_q * a_mt_q);
  end

  // square root pipe
  logic [SqrtSteps:0] sv_q;
  sqrt_stage_t        sq_q [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0].face <= b_face_q;
    sq_q[0].ns   <= b_ns_q;
    sq_q[0].nt   <= b_nt_q;
    sq_q[0].ms   <= b_ms_q;
    sq_q[0].mt   <= b_mt_q;
    sq_q[0].rem  <= '0;
    sq_q[0].root <= '0;
    sq_q[0].v    <= 32'(b_ss_q) + 32'(b_tt_q) + 32'h4000_0000;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else begin
        sv_q[k+1] <= sv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= sqrt_step(sq_q[k]);
    end
  end

  // axis mapping and radius products
  sqrt_stage_t sq_end;
  face_map_t   fmap;
  logic        dv_d;
  logic        pv_q;
  logic        p_ok_q;
  logic [2:0]  p_neg_q;
  logic [31:0] p_len_q;
  logic [30:0] p_prod_q [3];

  assign sq_end = sq_q[SqrtSteps];
  assign fmap   = face_map(sq_end.face);
  assign dv_d   = sv_q[SqrtSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_ok_q  <= (sq_end.face < FaceW'(FaceCount));
    p_len_q <= sq_end.root;
    for (int a = 0; a < 3; a++) begin
      case (fmap[a].src)
        SrcS: begin
          p_neg_q[a]  <= fmap[a].neg ^ sq_end.ns;
          p_prod_q[a] <= 31'(radius_q * sq_end.ms);
        end
        SrcT: begin
          p_neg_q[a]  <= fmap[a].neg ^ sq_end.nt;
          p_prod_q[a] <= 31'(radius_q * sq_end.mt);
        end
        default: begin
          p_neg_q[a]  <= fmap[a].neg;
          p_prod_q[a] <= {1'b0, radius_q, 15'd0};
        end
      endcase
    end
  end

  // scaling division pipe
  logic [OutSteps:0] ov_q;
  out_stage_t        oq_q [OutSteps+1];
  logic [30:0]       half_len;

  assign half_len = p_len_q[31:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q[0] <= 1'b0;
    end else begin
      ov_q[0] <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oq_q[0].ok  <= p_ok_q;
    oq_q[0].neg <= p_neg_q;
    oq_q[0].len <= p_len_q;
    for (int a = 0; a < 3; a++) begin
      oq_q[0].ax[a].rem <= 32'(p_prod_q[a]) + 32'(half_len[30:OutSteps]);
      oq_q[0].ax[a].lo  <= half_len[OutSteps-1:0];
      oq_q[0].ax[a].quo <= '0;
    end
  end

  for (genvar k = 0; k < OutSteps; k++) begin : g_odiv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ov_q[k+1] <= 1'b0;
      end else begin
        ov_q[k+1] <= ov_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      oq_q[k+1].ok  <= oq_q[k].ok;
      oq_q[k+1].neg <= oq_q[k].neg;
      oq_q[k+1].len <= oq_q[k].len;
      for (int a = 0; a < 3; a++) begin
        oq_q[k+1].ax[a] <= odiv_step(oq_q[k].ax[a], oq_q[k].len);
      end
    end
  end

  // output register
  out_stage_t           oq_end;
  logic                 valid_q;
  logic [PosW-1:0]      pos_d [3];
  logic [PosW-1:0]      pos_q [3];

  assign oq_end = oq_q[OutSteps];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!oq_end.ok) begin
        pos_d[a] = '0;
      end else if (oq_end.neg[a]) begin
        pos_d[a] = PosW'(0) - oq_end.ax[a].quo;
      end else begin
        pos_d[a] = oq_end.ax[a].quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ov_q[OutSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      pos_q[a] <= pos_d[a];
    end
  end

  assign valid_o = valid_q;
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];

  // assertions
  logic [PosW:0]        rad_bound;
  logic signed [PosW:0] pos_x_ext;
  logic                 x_in_bound;
  assign rad_bound  = {2'b00, radius_q, 8'd0};
  assign pos_x_ext  = $signed({pos_x_o[PosW-1], pos_x_o});
  assign x_in_bound = (pos_x_ext <= $signed(rad_bound)) && (pos_x_ext >= -$signed(rad_bound));

  `CFS_ASSERT_DLY(a_latency, start_i && !busy_o, Latency, valid_o, "beat lost in pipe")
  `CFS_ASSERT(a_no_phantom, !valid_o || $past(start_i, Latency), "beat without input")
  `CFS_ASSERT(a_x_bound, !valid_o || x_in_bound, "x beyond radius")
  `CFS_ASSERT(a_sqrt_floor, !dv_d || (sq_end.rem <= {1'b0, sq_end.root, 1'b0}), "sqrt rem")

endmodule

FILE: tb/sv/cube_face_grid_to_sphere_checker.sv
// ----------------------------------------------------------------------------
// cube_face_grid_to_sphere_checker
// predicts the sphere vertex of every accepted grid point and compares each
// result beat in order against it, tracking the radius and grid size written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cube_face_grid_to_sphere_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [cfsph_pkg::FaceW-1:0]    face_i,
  input  logic [cfsph_pkg::CoordW-1:0]   column_i,
  input  logic [cfsph_pkg::CoordW-1:0]   row_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_addr_i,
  input  logic [cfsph_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                           valid_i,
  input  logic [cfsph_pkg::PosW-1:0]     pos_x_i,
  input  logic [cfsph_pkg::PosW-1:0]     pos_y_i,
  input  logic [cfsph_pkg::PosW-1:0]     pos_z_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             results_o
);
  import cfsph_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic [PosW-1:0] z;
  } vertex_t;

  // per face: axis of tangent s, tangent t, normal, and their signs
  localparam int AxS[6]  = '{0, 2, 0, 2, 0, 0};
  localparam int AxT[6]  = '{1, 1, 1, 1, 2, 2};
  localparam int AxN[6]  = '{2, 0, 2, 0, 1, 1};
  localparam int SgS[6]  = '{1, -1, -1, 1, 1, 1};
  localparam int SgT[6]  = '{1, 1, 1, 1, -1, 1};
  localparam int SgN[6]  = '{1, 1, -1, -1, 1, -1};

  logic [RadiusW-1:0] radius_q;
  logic [GridW-1:0]   grid_q;
  vertex_t            vertex_q[$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint tangent(longint idx, longint span);
    longint u;
    if (idx > span) idx = span;
    u = (idx * 65536 + span / 2) / span;
    return u - 32768;
  endfunction

  function automatic logic [PosW-1:0] scale_axis(longint c, longint len, longint rad);
    longint mag, q;
    mag = (c < 0) ? -c : c;
    q = ((rad * mag) * (64'sd1 <<< 24) + len / 2) / len;
    if (c < 0) q = -q;
    return q[PosW-1:0];
  endfunction

  function automatic vertex_t sphere_vertex(logic [FaceW-1:0] f, logic [CoordW-1:0] c,
                                            logic [CoordW-1:0] r);
    longint n, s, t, len;
    longint p[3];
    logic [63:0] q;
    vertex_t v;
    v = '0;
    if (f > 5) return v;
    n = grid_q;
    if (n < 2) n = 2;
    if (n > GridMax) n = GridMax;
    s = tangent(c, n - 1);
    t = tangent(r, n - 1);
    p[AxS[f]] = SgS[f] * s;
    p[AxT[f]] = SgT[f] * t;
    p[AxN[f]] = SgN[f] * 32768;
    q = s * s + t * t + 64'd32768 * 32768;
    len = root64(q << 32);
    v.x = scale_axis(p[0], len, radius_q);
    v.y = scale_axis(p[1], len, radius_q);
    v.z = scale_axis(p[2], len, radius_q);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t want;
    if (!rst_ni) begin
      radius_q  <= RadiusReset;
      grid_q    <= GridReset;
      errors_o  <= 0;
      results_o <= 0;
      pending_o <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgRadius) radius_q <= cfg_wdata_i[RadiusW-1:0];
        else                         grid_q   <= cfg_wdata_i[GridW-1:0];
      end
      if (start_i && !busy_i) vertex_q.push_back(sphere_vertex(face_i, column_i, row_i));
      if (valid_i) begin
        results_o <= results_o + 1;
        if (vertex_q.size() == 0) begin
          $display("%0t: result beat with nothing expected (%h %h %h)", $time,
                   pos_x_i, pos_y_i, pos_z_i);
          errors_o <= errors_o + 1;
        end else begin
          want = vertex_q.pop_front();
          if (want.x !== pos_x_i || want.y !== pos_y_i || want.z !== pos_z_i) begin
            $display("%0t: vertex mismatch expected x=%h y=%h z=%h got x=%h y=%h z=%h",
                     $time, want.x, want.y, want.z, pos_x_i, pos_y_i, pos_z_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= vertex_q.size();
    end
  end

endmodule

FILE: tb/sv/cube_face_grid_to_sphere_top_tb.sv
// ----------------------------------------------------------------------------
// cube_face_grid_to_sphere_top_tb
// drives grid points at random rates through several radius and grid size
// settings, including extremes and out-of-range values, with a checker
// comparing every vertex against its own prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cube_face_grid_to_sphere_top_tb;
  import cfsph_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [FaceW-1:0]   face_i = '0;
  logic [CoordW-1:0]  column_i = '0;
  logic [CoordW-1:0]  row_i = '0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_addr_i = 1'b0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               valid_o;
  logic [PosW-1:0]    pos_x_o, pos_y_o, pos_z_o;
  int                 errors, pending, results;
  int                 points_sent = 0;
  int                 quiet_cycles = 0;
  bit                 steady = 0;

  always #4 clk_i = ~clk_i;

  cube_face_grid_to_sphere_top u_top (.*);

  cube_face_grid_to_sphere_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .face_i, .column_i, .row_i,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i, .valid_i(valid_o), .pos_x_i(pos_x_o),
    .pos_y_i(pos_y_o), .pos_z_i(pos_z_o), .errors_o(errors), .pending_o(pending),
    .results_o(results)
  );

  // watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_point(logic [FaceW-1:0] f, logic [CoordW-1:0] c, logic [CoordW-1:0] r);
    while (!steady && $urandom_range(99) < 25) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i  = 1'b1;
    face_i   = f;
    column_i = c;
    row_i    = r;
    do @(posedge clk_i); while (busy_o);
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_points(int count, int span);
    int lim;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 2);
      lim = ($urandom_range(9) == 0) ? 255 : span - 1;
      send_point(($urandom_range(19) == 0) ? FaceW'($urandom_range(7, 6))
                                           : FaceW'($urandom_range(5)),
                 CoordW'($urandom_range(lim)), CoordW'($urandom_range(lim)));
    end
    steady = 0;
  endtask

  initial begin
    int radius_set[8];
    int grid_set[8];
    int span;
    radius_set = '{6300, 1, 32767, 0, 1000, 32767, 257, 12345};
    grid_set   = '{256, 2, 256, 3, 0, 511, 17, 1};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners, centers and every face including the unused codes
    for (int f = 0; f < 8; f++) begin
      send_point(FaceW'(f), 8'd0, 8'd0);
      send_point(FaceW'(f), 8'd255, 8'd255);
    end
    send_point(3'd0, 8'd255, 8'd0);
    send_point(3'd1, 8'd0, 8'd255);
    send_point(3'd4, 8'd128, 8'd127);
    send_point(3'd5, 8'd170, 8'd85);
    random_points(80, 256);

    for (int p = 1; p < 8; p++) begin
      write_reg(CfgRadius, CfgW'(radius_set[p]));
      write_reg(CfgGrid, CfgW'(grid_set[p]));
      span = (grid_set[p] < 2) ? 2 : (grid_set[p] > 256) ? 256 : grid_set[p];
      send_point(3'd2, 8'd255, 8'd255);
      random_points(100, span);
    end
    write_reg(CfgGrid, CfgW'($urandom_range(32767)));
    random_points(20, 256);

    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    $display("sent %0d grid points over 9 radius/grid settings, %0d vertices checked",
             points_sent, results);
    $display("settings spanned radius 0..32767 and grid sizes below 2 up to above 256");
    if (errors == 0 && pending == 0 && results == points_sent) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cfsph_pkg.sv
hw/rtl/cube_face_grid_to_sphere_top.sv
tb/sv/cube_face_grid_to_sphere_checker.sv
tb/sv/cube_face_grid_to_sphere_top_tb.sv
